// ----- rtl/core/ihpwl_pkg.sv -----
// ----------------------------------------------------------------------------
// ihpwl_pkg
// Shared constants, opcodes and status codes of the incremental HPWL engine.
// ----------------------------------------------------------------------------
package ihpwl_pkg;

	localparam int IHPWL_MAX_NODES         = 256;
	localparam int IHPWL_MAX_NETS          = 256;
	localparam int IHPWL_MAX_PINS          = 1024;
	localparam int IHPWL_MAX_NETS_PER_NODE = 8;
	localparam int IHPWL_COORD_BITS        = 16;

	localparam int OUT_W   = 25;
	localparam int NCNT_W  = 9;
	localparam int IN_W    = 56;
	localparam int RES_W   = 32;

	typedef logic [2:0] opcode_t;
	localparam opcode_t OP_CLEAR = 3'd0;
	localparam opcode_t OP_SET   = 3'd1;
	localparam opcode_t OP_ADD   = 3'd2;
	localparam opcode_t OP_MOVE  = 3'd3;
	localparam opcode_t OP_SWAP  = 3'd4;
	localparam opcode_t OP_TOTAL = 3'd5;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_CAP   = 2'd2;

endpackage

// ----- rtl/core/incremental_hpwl_netlist_engine_top.sv -----
// ----------------------------------------------------------------------------
// incremental_hpwl_netlist_engine_top
// Placement wirelength engine: node positions, nets and per-net HPWL held in
// synchronous memories, updated incrementally by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// One item is processed at a time; the next beat is taken as soon as the
// sequencer is back in idle, while the previous result may still sit in the
// output register. Move walks the pins of each net linked to the node that
// has two pins or more; the pin walk reads one pin and one node position
// per cycle. Swap does the net walks of both nodes. Total sums the stored
// values of all nets, or with recompute_all walks every net anew. Clear nets
// sweeps the node degree memory. A stalled result beat holds the sequencer
// at its last step. After reset a clearing pass over all MAX_NODES entries
// zeroes positions and degrees; no item is taken meanwhile.
module incremental_hpwl_netlist_engine_top #(
	parameter int MAX_NODES         = ihpwl_pkg::IHPWL_MAX_NODES,
	parameter int MAX_NETS          = ihpwl_pkg::IHPWL_MAX_NETS,
	parameter int MAX_PINS          = ihpwl_pkg::IHPWL_MAX_PINS,
	parameter int MAX_NETS_PER_NODE = ihpwl_pkg::IHPWL_MAX_NETS_PER_NODE,
	parameter int COORD_BITS        = ihpwl_pkg::IHPWL_COORD_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// opcode[2:0], node_a[10:3], node_b[18:11], x_coord[34:19], y_coord[50:35]
	input  logic [ihpwl_pkg::IN_W-1:0] s_tdata,
	input  logic                       s_tlast,   // pin_last
	input  logic                       s_tuser,   // recompute_all
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// total_hpwl[24:0], status[26:25]
	output logic [ihpwl_pkg::RES_W-1:0] m_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import ihpwl_pkg::*;

	localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NET_W   = (MAX_NETS > 1) ? $clog2(MAX_NETS) : 1;
	localparam int PIN_W   = (MAX_PINS > 1) ? $clog2(MAX_PINS) : 1;
	localparam int LINKS   = MAX_NODES * MAX_NETS_PER_NODE;
	localparam int LINK_AW = (LINKS > 1) ? $clog2(LINKS) : 1;
	localparam int NETC_W  = $clog2(MAX_NETS + 1);
	localparam int PCNT_W  = $clog2(MAX_PINS + 1);
	localparam int DEG_W   = $clog2(MAX_NETS_PER_NODE + 1);
	localparam int C       = COORD_BITS;
	localparam int HPWL_W  = COORD_BITS + 1;
	localparam int TOT_RAW = HPWL_W + $clog2(MAX_NETS) + 1;
	localparam int TOT_W   = (TOT_RAW > OUT_W) ? TOT_RAW : OUT_W + 1;
	localparam int SPAN_W  = PIN_W + PCNT_W;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_CLR  = 14'b00000000000010,
		S_DISP = 14'b00000000000100,
		S_PIN  = 14'b00000000001000,
		S_SWA  = 14'b00000000010000,
		S_SWB  = 14'b00000000100000,
		S_MVP  = 14'b00000001000000,
		S_MVD  = 14'b00000010000000,
		S_LNK  = 14'b00000100000000,
		S_LNW  = 14'b00001000000000,
		S_NET  = 14'b00010000000000,
		S_RUN  = 14'b00100000000000,
		S_FIN  = 14'b01000000000000,
		S_TOT  = 14'b10000000000000
	} state_t;

	// memories
	logic [2*C-1:0]    pos_mem  [MAX_NODES];
	logic [DEG_W-1:0]  deg_mem  [MAX_NODES];
	logic [NET_W-1:0]  link_mem [LINKS];
	logic [SPAN_W-1:0] span_mem [MAX_NETS];
	logic [HPWL_W-1:0] wl_mem   [MAX_NETS];
	logic [NODE_W-1:0] pin_mem  [MAX_PINS];

	logic              pos_we, deg_we, link_we, span_we, wl_we, pin_we;
	logic [NODE_W-1:0] pos_wa, pos_ra, deg_wa, deg_ra;
	logic [2*C-1:0]    pos_wd, pos_rd_q;
	logic [DEG_W-1:0]  deg_wd, deg_rd_q;
	logic [LINK_AW-1:0] link_wa, link_ra;
	logic [NET_W-1:0]  link_wd, link_rd_q, span_wa, wl_wa, net_ra;
	logic [SPAN_W-1:0] span_wd, span_rd_q;
	logic [HPWL_W-1:0] wl_wd, wl_rd_q;
	logic [PIN_W-1:0]  pin_wa, pin_ra;
	logic [NODE_W-1:0] pin_wd, pin_rd_q;

	// control and item registers
	state_t            state_q;
	opcode_t           op_q;
	logic [7:0]        a_q, b_q;
	logic [C-1:0]      x_q, y_q;
	logic              last_q, rc_q;
	status_t           status_q;
	logic [NCNT_W-1:0] node_count_q;
	logic [NETC_W-1:0] nets_q, ti_q;
	logic [PCNT_W-1:0] pins_q, cur_cnt_q, left_q;
	logic [PIN_W-1:0]  cur_first_q, p_q;
	logic              open_q, clr_pos_q, second_q, v1_q, v2_q, seen_q;
	logic [NODE_W-1:0] clr_q, mv_node_q;
	logic [2*C-1:0]    mv_xy_q, oxy_q;
	logic [DEG_W-1:0]  deg_q, li_q;
	logic [NET_W-1:0]  net_q;
	logic [HPWL_W-1:0] old_q;
	logic [C-1:0]      lx_q, hx_q, ly_q, hy_q;
	logic [TOT_W-1:0]  tot_q;
	logic              m_tvalid_q;
	logic [RES_W-1:0]  m_tdata_q;

	logic              ok_a, ok_b, cap_err, out_free, fin_loop, emit;
	logic [NET_W-1:0]  cur_net;
	logic [PIN_W-1:0]  new_first;
	logic [PCNT_W-1:0] new_cnt;
	logic [HPWL_W-1:0] hpwl;
	logic [C-1:0]      px, py;
	logic [PIN_W-1:0]  sp_first;
	logic [PCNT_W-1:0] sp_cnt;
	logic [OUT_W-1:0]  sat_total;

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		pos_rd_q <= pos_mem[pos_ra];
	end
	always_ff @(posedge clk) begin
		if (deg_we) deg_mem[deg_wa] <= deg_wd;
		deg_rd_q <= deg_mem[deg_ra];
	end
	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		link_rd_q <= link_mem[link_ra];
	end
	always_ff @(posedge clk) begin
		if (span_we) span_mem[span_wa] <= span_wd;
		span_rd_q <= span_mem[net_ra];
	end
	always_ff @(posedge clk) begin
		if (wl_we) wl_mem[wl_wa] <= wl_wd;
		wl_rd_q <= wl_mem[net_ra];
	end
	always_ff @(posedge clk) begin
		if (pin_we) pin_mem[pin_wa] <= pin_wd;
		pin_rd_q <= pin_mem[pin_ra];
	end

	assign ok_a      = ({1'b0, a_q} < node_count_q) && (32'(a_q) < MAX_NODES);
	assign ok_b      = ({1'b0, b_q} < node_count_q) && (32'(b_q) < MAX_NODES);
	assign cap_err   = (!open_q && nets_q >= NETC_W'(MAX_NETS)) ||
	                   (pins_q >= PCNT_W'(MAX_PINS)) ||
	                   (deg_rd_q >= DEG_W'(MAX_NETS_PER_NODE));
	assign cur_net   = open_q ? NET_W'(nets_q - 1'b1) : NET_W'(nets_q);
	assign new_first = open_q ? cur_first_q : PIN_W'(pins_q);
	assign new_cnt   = open_q ? PCNT_W'(cur_cnt_q + 1'b1) : PCNT_W'(1);
	assign hpwl      = HPWL_W'({1'b0, hx_q} - {1'b0, lx_q}) +
	                   HPWL_W'({1'b0, hy_q} - {1'b0, ly_q});
	assign px        = pos_rd_q[2*C-1:C];
	assign py        = pos_rd_q[C-1:0];
	assign sp_first  = span_rd_q[SPAN_W-1:PCNT_W];
	assign sp_cnt    = span_rd_q[PCNT_W-1:0];
	assign out_free  = !m_tvalid_q || m_tready;
	assign sat_total = (|tot_q[TOT_W-1:OUT_W]) ? {OUT_W{1'b1}} : tot_q[OUT_W-1:0];
	// a net has just been walked and its result must be folded in
	assign fin_loop  = (op_q == OP_TOTAL) ? (ti_q != nets_q) :
	                   ((op_q == OP_MOVE || op_q == OP_SWAP) &&
	                    status_q == ST_OK && li_q != deg_q);
	assign emit      = (state_q == S_FIN) && !fin_loop && out_free;

	// memory port control
	always_comb begin
		pos_we  = 1'b0; pos_wa  = mv_node_q; pos_wd = mv_xy_q; pos_ra = pin_rd_q;
		deg_we  = 1'b0; deg_wa  = NODE_W'(a_q); deg_wd = '0; deg_ra = mv_node_q;
		link_we = 1'b0;
		link_wa = LINK_AW'(32'(a_q) * MAX_NETS_PER_NODE) + LINK_AW'(deg_rd_q);
		link_wd = cur_net;
		link_ra = LINK_AW'(32'(mv_node_q) * MAX_NETS_PER_NODE) + LINK_AW'(li_q);
		span_we = 1'b0; span_wa = cur_net; span_wd = {new_first, new_cnt};
		wl_we   = 1'b0; wl_wa   = net_q; wl_wd = hpwl;
		net_ra  = link_rd_q;
		pin_we  = 1'b0; pin_wa  = PIN_W'(pins_q); pin_wd = NODE_W'(a_q); pin_ra = p_q;
		unique case (state_q)
			S_CLR: begin
				deg_we = 1'b1;
				deg_wa = clr_q;
				pos_we = clr_pos_q;
				pos_wa = clr_q;
				pos_wd = '0;
			end
			S_DISP: begin
				if (op_q == OP_SET && ok_a) begin
					pos_we = 1'b1;
					pos_wa = NODE_W'(a_q);
					pos_wd = {x_q, y_q};
					deg_we = 1'b1;
				end
				deg_ra = NODE_W'(a_q);
				pos_ra = NODE_W'(a_q);
			end
			S_PIN: begin
				if (!cap_err) begin
					span_we = 1'b1;
					wl_we   = !open_q;
					wl_wa   = cur_net;
					wl_wd   = '0;
					pin_we  = 1'b1;
					link_we = 1'b1;
					deg_we  = 1'b1;
					deg_wd  = deg_rd_q + 1'b1;
				end
			end
			S_SWA: pos_ra = NODE_W'(b_q);
			S_MVP: pos_we = 1'b1;
			S_TOT: net_ra = NET_W'(ti_q);
			S_FIN: wl_we  = fin_loop;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			clr_pos_q    <= 1'b1;
			node_count_q <= NCNT_W'(256);
			nets_q       <= '0;
			pins_q       <= '0;
			open_q       <= 1'b0;
			tot_q        <= '0;
			m_tvalid_q   <= 1'b0;
			v1_q         <= 1'b0;
			v2_q         <= 1'b0;
			second_q     <= 1'b0;
		end else begin
			if (psel && penable && pwrite && !paddr[2])
				node_count_q <= pwdata[NCNT_W-1:0];
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q   <= s_tdata[2:0];
						a_q    <= s_tdata[10:3];
						b_q    <= s_tdata[18:11];
						x_q    <= C'(s_tdata[34:19]);
						y_q    <= C'(s_tdata[50:35]);
						last_q <= s_tlast;
						rc_q   <= s_tuser;
						state_q <= S_DISP;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NODE_W'(MAX_NODES - 1)) begin
						clr_pos_q <= 1'b0;
						state_q   <= clr_pos_q ? S_IDLE : S_FIN;
					end
				end
				S_DISP: begin
					status_q  <= ST_OK;
					mv_node_q <= NODE_W'(a_q);
					mv_xy_q   <= {x_q, y_q};
					second_q  <= 1'b0;
					ti_q      <= '0;
					state_q   <= S_FIN;
					case (op_q)
						OP_CLEAR: begin
							nets_q  <= '0;
							pins_q  <= '0;
							open_q  <= 1'b0;
							tot_q   <= '0;
							clr_q   <= '0;
							state_q <= S_CLR;
						end
						OP_SET: if (!ok_a) status_q <= ST_RANGE;
						OP_ADD: begin
							if (!ok_a) status_q <= ST_RANGE;
							else state_q <= S_PIN;
						end
						OP_MOVE: begin
							if (!ok_a) status_q <= ST_RANGE;
							else state_q <= S_MVP;
						end
						OP_SWAP: begin
							if (!ok_a || !ok_b) status_q <= ST_RANGE;
							else state_q <= S_SWA;
						end
						OP_TOTAL: begin
							tot_q   <= '0;
							state_q <= S_TOT;
						end
						default: begin
						end
					endcase
				end
				S_PIN: begin
					state_q <= S_FIN;
					if (cap_err) begin
						status_q <= ST_CAP;
					end else begin
						cur_first_q <= new_first;
						cur_cnt_q   <= new_cnt;
						pins_q      <= pins_q + 1'b1;
						if (!open_q) nets_q <= nets_q + 1'b1;
						open_q <= !last_q;
					end
				end
				S_SWA: begin
					oxy_q   <= pos_rd_q;
					state_q <= S_SWB;
				end
				S_SWB: begin
					mv_xy_q <= pos_rd_q;
					state_q <= S_MVP;
				end
				S_MVP: state_q <= S_MVD;
				S_MVD: begin
					deg_q   <= deg_rd_q;
					li_q    <= '0;
					state_q <= S_LNK;
				end
				S_LNK: begin
					if (li_q == deg_q) begin
						if (op_q == OP_SWAP && !second_q) begin
							second_q  <= 1'b1;
							mv_node_q <= NODE_W'(b_q);
							mv_xy_q   <= oxy_q;
							state_q   <= S_MVP;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						state_q <= S_LNW;
					end
				end
				S_LNW: begin
					net_q   <= link_rd_q;
					state_q <= S_NET;
				end
				S_TOT: begin
					if (ti_q == nets_q) begin
						state_q <= S_FIN;
					end else begin
						net_q   <= NET_W'(ti_q);
						state_q <= S_NET;
					end
				end
				S_NET: begin
					old_q  <= (op_q == OP_TOTAL) ? '0 : wl_rd_q;
					p_q    <= sp_first;
					left_q <= sp_cnt;
					seen_q <= 1'b0;
					v1_q   <= 1'b0;
					v2_q   <= 1'b0;
					lx_q   <= '0; hx_q <= '0; ly_q <= '0; hy_q <= '0;
					if (op_q == OP_TOTAL && !rc_q) begin
						tot_q   <= tot_q + TOT_W'(wl_rd_q);
						ti_q    <= ti_q + 1'b1;
						state_q <= S_TOT;
					end else if (sp_cnt < PCNT_W'(2)) begin
						left_q  <= '0;
						state_q <= S_RUN;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					v1_q <= (left_q != '0);
					v2_q <= v1_q;
					if (left_q != '0) begin
						p_q    <= p_q + 1'b1;
						left_q <= left_q - 1'b1;
					end
					if (v2_q) begin
						seen_q <= 1'b1;
						if (!seen_q || px < lx_q) lx_q <= px;
						if (!seen_q || px > hx_q) hx_q <= px;
						if (!seen_q || py < ly_q) ly_q <= py;
						if (!seen_q || py > hy_q) hy_q <= py;
					end
					if (left_q == '0 && !v1_q && !v2_q)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_loop) begin
						tot_q <= tot_q + TOT_W'(hpwl) - TOT_W'(old_q);
						if (op_q == OP_TOTAL) begin
							ti_q    <= ti_q + 1'b1;
							state_q <= S_TOT;
						end else begin
							li_q    <= li_q + 1'b1;
							state_q <= S_LNK;
						end
					end else if (emit) begin
						m_tdata_q <= RES_W'({status_q, sat_total});
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign prdata   = 32'(node_count_q);
	assign pready   = 1'b1;

	assert property (@(posedge clk) disable iff (!arst_n) pins_q <= PCNT_W'(MAX_PINS))
		else $error("pin count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) nets_q <= NETC_W'(MAX_NETS))
		else $error("net count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n) open_q |-> nets_q != '0)
		else $error("open net without any net allocated");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !s_tready)
		else $error("beat taken during clearing sweep");

endmodule
